// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset
`define GH_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included
`define GH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/ghlsq_pkg.sv =====
package ghlsq_pkg;

  localparam int MAX_COLUMNS = 32;
  localparam int DATA_WIDTH  = 32;
  localparam int FRAC        = 16;

  localparam int CNT_W   = $clog2(MAX_COLUMNS + 1);
  localparam int COL_W   = $clog2(MAX_COLUMNS);
  localparam int ROW_W   = $clog2(MAX_COLUMNS + 2);
  localparam int H_AW    = ROW_W + COL_W;
  localparam int H_DEPTH = 1 << H_AW;
  localparam int PROD_W  = 2 * DATA_WIDTH;
  localparam int RP_W    = PROD_W - FRAC;
  localparam int ACC_W   = RP_W + CNT_W + 2;
  localparam int DIV_W   = DATA_WIDTH + FRAC;
  localparam int SQ_W    = 2 * DATA_WIDTH;

  localparam int OPC_W   = 2;
  localparam int ROWIN_W = 6;
  localparam int IDX_W   = 6;
  localparam int STAT_W  = 3;
  localparam int TOL_W   = 31;
  localparam int ACT_W   = 6;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  localparam data_t VMAX  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t VMIN  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam data_t ONE_Q = data_t'(1 << FRAC);

  localparam logic [ACT_W-1:0] ACT_RESET = ACT_W'(30);

  localparam logic [OPC_W-1:0] OP_START = 2'd0;
  localparam logic [OPC_W-1:0] OP_ENTRY = 2'd1;
  localparam logic [OPC_W-1:0] OP_SOLVE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
  localparam logic [STAT_W-1:0] ST_HAPPY = 3'd1;
  localparam logic [STAT_W-1:0] ST_NULL  = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY = 3'd4;

  localparam logic KIND_RESID = 1'b0;
  localparam logic KIND_COEF  = 1'b1;

  localparam logic REG_TOL = 1'b0;
  localparam logic REG_ACT = 1'b1;

  typedef struct packed {
    logic [OPC_W-1:0]   opcode;
    logic [ROWIN_W-1:0] row_index;
    data_t              data_value;
    logic               column_end;
  } in_item_t;

  typedef struct packed {
    logic              result_kind;
    data_t             result_value;
    logic [IDX_W-1:0]  coefficient_index;
    logic [STAT_W-1:0] status;
    logic              last_result;
  } out_item_t;

  typedef struct packed {
    logic  start;
    data_t num;
    data_t den;
  } div_req_t;

  typedef struct packed {
    logic  busy;
    data_t quot;
  } div_rsp_t;

  typedef struct packed {
    logic            start;
    logic [SQ_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic                  busy;
    logic [DATA_WIDTH-1:0] root;
  } sqrt_rsp_t;

  typedef enum logic [5:0] {
    S_IDLE, S_DISP,
    S_CL0, S_CL1,
    S_RT0, S_RT1, S_RT2, S_RT3, S_RT4, S_RT5,
    S_LO0, S_LO1,
    S_SQ0, S_SQ1, S_SQ2, S_SQ3, S_WAIT, S_DEC,
    S_DC, S_DCW, S_DS, S_DSW,
    S_N0, S_N1, S_N2, S_N3, S_N4,
    S_SV1, S_SV2, S_XW,
    S_K0, S_K1, S_KJ0, S_KJ1, S_KD,
    S_EMIT
  } state_t;

  function automatic data_t sat_acc(logic signed [ACC_W-1:0] x);
    if (x > ACC_W'(VMAX)) return VMAX;
    if (x < ACC_W'(VMIN)) return VMIN;
    return x[DATA_WIDTH-1:0];
  endfunction

  function automatic data_t abs_q(data_t x);
    if (x == VMIN) return VMAX;
    return x[DATA_WIDTH-1] ? -x : x;
  endfunction

  function automatic logic signed [RP_W-1:0] round_prod(logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + PROD_W'(1 << (FRAC - 1));
    return t[PROD_W-1:FRAC];
  endfunction

  function automatic logic [H_AW-1:0] haddr(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    return {r, c};
  endfunction

endpackage

// ===== design/ghlsq_in_if.sv =====
interface ghlsq_in_if;
  logic                valid;
  logic                ready;
  ghlsq_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/ghlsq_out_if.sv =====
interface ghlsq_out_if;
  logic                 valid;
  logic                 ready;
  ghlsq_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/ghlsq_div.sv =====
module ghlsq_div (
  input  logic                clk,
  input  logic                rst,
  input  ghlsq_pkg::div_req_t req,
  output ghlsq_pkg::div_rsp_t rsp
);

  localparam int DW  = ghlsq_pkg::DATA_WIDTH;
  localparam int NW  = ghlsq_pkg::DIV_W;
  localparam int CW  = $clog2(NW + 1);
  localparam logic [NW-1:0] NEG_LIM = NW'(1) << (DW - 1);
  localparam logic [NW-1:0] POS_LIM = NEG_LIM - NW'(1);

  logic                 run;
  logic [CW-1:0]        cnt;
  logic [NW-1:0]        num;
  logic [NW-1:0]        quo;
  logic [DW-1:0]        rem;
  logic [DW-1:0]        den;
  logic                 neg;
  ghlsq_pkg::data_t     quot;
  logic [DW:0]          trial;
  logic [DW-1:0]        mag_a;
  logic [DW-1:0]        mag_b;

  assign trial = {rem, num[NW-1]};
  assign mag_a = req.num[DW-1] ? DW'(-req.num) : DW'(req.num);
  assign mag_b = req.den[DW-1] ? DW'(-req.den) : DW'(req.den);

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else if (req.start) begin
      if (req.den == '0) begin
        run <= 1'b0;
      end else begin
        run <= 1'b1;
      end
    end else if (run && cnt == '0) begin
      run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num <= NW'(mag_a) << ghlsq_pkg::FRAC;
      den <= mag_b;
      rem <= '0;
      quo <= '0;
      cnt <= CW'(NW);
      neg <= req.num[DW-1] ^ req.den[DW-1];
      if (req.den == '0) begin
        if (req.num == '0) begin
          quot <= '0;
        end else if (req.num[DW-1]) begin
          quot <= ghlsq_pkg::VMIN;
        end else begin
          quot <= ghlsq_pkg::VMAX;
        end
      end
    end else if (run) begin
      if (cnt != '0) begin
        if (trial >= {1'b0, den}) begin
          rem <= DW'(trial - {1'b0, den});
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= trial[DW-1:0];
          quo <= {quo[NW-2:0], 1'b0};
        end
        num <= {num[NW-2:0], 1'b0};
        cnt <= cnt - CW'(1);
      end else if (neg) begin
        quot <= (quo > NEG_LIM) ? ghlsq_pkg::VMIN : -quo[DW-1:0];
      end else begin
        quot <= (quo > POS_LIM) ? ghlsq_pkg::VMAX : quo[DW-1:0];
      end
    end
  end

  assign rsp.busy = run;
  assign rsp.quot = quot;

endmodule

// ===== design/ghlsq_sqrt.sv =====
module ghlsq_sqrt (
  input  logic                 clk,
  input  logic                 rst,
  input  ghlsq_pkg::sqrt_req_t req,
  output ghlsq_pkg::sqrt_rsp_t rsp
);

  localparam int RW = ghlsq_pkg::DATA_WIDTH;
  localparam int VW = ghlsq_pkg::SQ_W;
  localparam int MW = RW + 3;
  localparam int CW = $clog2(RW + 1);

  logic          run;
  logic [CW-1:0] cnt;
  logic [VW-1:0] val;
  logic [MW-1:0] rem;
  logic [RW-1:0] root;
  logic [MW-1:0] cur;
  logic [MW-1:0] trial;

  assign cur   = {rem[MW-3:0], val[VW-1:VW-2]};
  assign trial = MW'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else if (req.start) begin
      run <= 1'b1;
    end else if (run && cnt == CW'(1)) begin
      run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      val  <= req.radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= CW'(RW);
    end else if (run) begin
      if (cur >= trial) begin
        rem  <= cur - trial;
        root <= {root[RW-2:0], 1'b1};
      end else begin
        rem  <= cur;
        root <= {root[RW-2:0], 1'b0};
      end
      val <= {val[VW-3:0], 2'b00};
      cnt <= cnt - CW'(1);
    end
  end

  assign rsp.busy = run;
  assign rsp.root = root;

endmodule

// ===== design/givens_hessenberg_lsq_update.sv =====
// Givens-rotation least-squares core for GMRES in signed Q16.16. A start request loads the
// residual norm and clears the column count; entry requests store one Hessenberg column
// and the entry marked column_end closes it with one residual report; a solve request
// back-substitutes and returns the coefficients from the highest index down. Requests are
// taken one at a time. Closing a column passes each stored rotation through the one shared
// 32x32 multiplier and the Hessenberg memory port, then runs the radix-2 divider once
// alongside the square root and twice more unless the column breaks down. A solve divides
// for each coefficient (the top one only when its diagonal is nonzero) and passes each
// product of the back-substitution sum through the shared multiplier. The state sits in
// memories with one write port and one registered read port each; no clearing pass.
`include "assert_macros.svh"

module givens_hessenberg_lsq_update (
  input  logic                            clk,
  input  logic                            rst,
  ghlsq_in_if.sink                        cmd,
  ghlsq_out_if.source                     rsp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ghlsq_pkg::APB_AW-1:0]    paddr,
  input  logic [ghlsq_pkg::APB_DW-1:0]    pwdata,
  output logic [ghlsq_pkg::APB_DW-1:0]    prdata,
  output logic                            pready
);

  localparam int DW    = ghlsq_pkg::DATA_WIDTH;
  localparam int CNT_W = ghlsq_pkg::CNT_W;
  localparam int COL_W = ghlsq_pkg::COL_W;
  localparam int ROW_W = ghlsq_pkg::ROW_W;
  localparam int H_AW  = ghlsq_pkg::H_AW;
  localparam int ACC_W = ghlsq_pkg::ACC_W;
  localparam int RP_W  = ghlsq_pkg::RP_W;
  localparam int PW    = ghlsq_pkg::PROD_W;
  localparam int MAXC  = ghlsq_pkg::MAX_COLUMNS;

  ghlsq_pkg::state_t    state;
  ghlsq_pkg::state_t    state_next;
  ghlsq_pkg::state_t    e_ret;
  ghlsq_pkg::in_item_t  item;
  ghlsq_pkg::out_item_t e_item;
  ghlsq_pkg::out_item_t o_item;
  logic                 o_valid;

  logic [ghlsq_pkg::TOL_W-1:0] tol;
  logic [ghlsq_pkg::ACT_W-1:0] active;

  logic [CNT_W-1:0] cc;
  logic [CNT_W-1:0] top;
  logic [CNT_W-1:0] j;
  logic [CNT_W-1:0] k;
  logic [COL_W-1:0] it;
  logic             zflag;

  ghlsq_pkg::data_t a_reg, b_reg, c_reg, s_reg, lo, rv, hd, delta;
  logic signed [ACC_W-1:0] acc;
  logic [ghlsq_pkg::SQ_W-1:0] sq;
  logic signed [PW-1:0] p;
  logic signed [RP_W-1:0] rp;
  ghlsq_pkg::data_t mul_a, mul_b;

  ghlsq_pkg::data_t hmem [ghlsq_pkg::H_DEPTH];
  ghlsq_pkg::data_t cmem [MAXC];
  ghlsq_pkg::data_t smem [MAXC];
  ghlsq_pkg::data_t rmem [MAXC + 1];
  ghlsq_pkg::data_t xmem [MAXC + 1];
  ghlsq_pkg::data_t h_q, c_q, s_q, r_q, x_q;

  logic             h_we, c_we, s_we, r_we, x_we;
  logic [H_AW-1:0]  h_waddr, h_raddr;
  logic [COL_W-1:0] cs_waddr, cs_raddr;
  logic [CNT_W-1:0] r_waddr, r_raddr, x_waddr, x_raddr;
  ghlsq_pkg::data_t h_wdata, c_wdata, s_wdata, r_wdata, x_wdata;

  ghlsq_pkg::div_req_t  div_req;
  ghlsq_pkg::div_rsp_t  div_rsp;
  ghlsq_pkg::sqrt_req_t sqrt_req;
  ghlsq_pkg::sqrt_rsp_t sqrt_rsp;

  logic [CNT_W-1:0] lim;
  logic             full;
  logic             row_ok;
  logic             emit_go;
  ghlsq_pkg::data_t dabs, labs, bnd, rneg;
  logic             happy;
  logic             brk;
  logic             start_acc;
  logic             seq_idle;

  ghlsq_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));
  ghlsq_sqrt u_sqrt (.clk(clk), .rst(rst), .req(sqrt_req), .rsp(sqrt_rsp));

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol    <= '0;
      active <= ghlsq_pkg::ACT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        ghlsq_pkg::REG_TOL: tol    <= pwdata[ghlsq_pkg::TOL_W-1:0];
        ghlsq_pkg::REG_ACT: active <= pwdata[ghlsq_pkg::ACT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ghlsq_pkg::REG_TOL: prdata = ghlsq_pkg::APB_DW'(tol);
      ghlsq_pkg::REG_ACT: prdata = ghlsq_pkg::APB_DW'(active);
      default:            prdata = '0;
    endcase
  end

  assign lim = (active == '0) ? CNT_W'(1) :
               (active > ghlsq_pkg::ACT_W'(MAXC)) ? CNT_W'(MAXC) : CNT_W'(active);
  assign full   = cc >= lim;
  assign row_ok = int'(item.row_index) <= int'(cc) + 1;

  // shared multiplier
  assign rp = ghlsq_pkg::round_prod(p);

  always_ff @(posedge clk) begin
    p <= mul_a * mul_b;
  end

  // breakdown test
  assign dabs  = ghlsq_pkg::abs_q(div_rsp.quot);
  assign labs  = ghlsq_pkg::abs_q(lo);
  assign bnd   = (DW'(tol) < dabs) ? DW'(tol) : dabs;
  assign happy = labs < bnd;
  assign brk   = happy || (delta == '0);
  assign rneg  = ghlsq_pkg::sat_acc(-ACC_W'(rp));

  // memories
  always_ff @(posedge clk) begin
    if (h_we) begin
      hmem[h_waddr] <= h_wdata;
    end
    h_q <= hmem[h_raddr];
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      cmem[cs_waddr] <= c_wdata;
    end
    c_q <= cmem[cs_raddr];
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      smem[cs_waddr] <= s_wdata;
    end
    s_q <= smem[cs_raddr];
  end

  always_ff @(posedge clk) begin
    if (r_we) begin
      rmem[r_waddr] <= r_wdata;
    end
    r_q <= rmem[r_raddr];
  end

  always_ff @(posedge clk) begin
    if (x_we) begin
      xmem[x_waddr] <= x_wdata;
    end
    x_q <= xmem[x_raddr];
  end

  // sequencer
  assign emit_go   = !o_valid || rsp.ready;
  assign cmd.ready = (state == ghlsq_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ghlsq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    h_we            = 1'b0;
    c_we            = 1'b0;
    s_we            = 1'b0;
    r_we            = 1'b0;
    x_we            = 1'b0;
    h_waddr         = '0;
    h_raddr         = '0;
    cs_waddr        = it;
    cs_raddr        = '0;
    r_waddr         = '0;
    r_raddr         = '0;
    x_waddr         = k;
    x_raddr         = '0;
    h_wdata         = '0;
    c_wdata         = '0;
    s_wdata         = '0;
    r_wdata         = '0;
    x_wdata         = '0;
    mul_a           = '0;
    mul_b           = '0;
    div_req         = '0;
    sqrt_req        = '0;
    unique case (state)
      ghlsq_pkg::S_IDLE: begin
        if (cmd.valid) begin
          state_next = ghlsq_pkg::S_DISP;
        end
      end
      ghlsq_pkg::S_DISP: begin
        case (item.opcode)
          ghlsq_pkg::OP_START: begin
            r_we       = 1'b1;
            r_waddr    = '0;
            r_wdata    = item.data_value;
            state_next = ghlsq_pkg::S_IDLE;
          end
          ghlsq_pkg::OP_ENTRY: begin
            if (full) begin
              state_next = item.column_end ? ghlsq_pkg::S_EMIT : ghlsq_pkg::S_IDLE;
            end else begin
              h_we       = row_ok;
              h_waddr    = ghlsq_pkg::haddr(ROW_W'(item.row_index), COL_W'(cc));
              h_wdata    = item.data_value;
              state_next = item.column_end ? ghlsq_pkg::S_CL0 : ghlsq_pkg::S_IDLE;
            end
          end
          ghlsq_pkg::OP_SOLVE: begin
            if (cc == '0) begin
              state_next = ghlsq_pkg::S_EMIT;
            end else begin
              h_raddr    = ghlsq_pkg::haddr(ROW_W'(cc - CNT_W'(1)), COL_W'(cc - CNT_W'(1)));
              r_raddr    = cc - CNT_W'(1);
              state_next = ghlsq_pkg::S_SV1;
            end
          end
          default: state_next = ghlsq_pkg::S_IDLE;
        endcase
      end
      ghlsq_pkg::S_CL0: begin
        h_raddr    = ghlsq_pkg::haddr('0, it);
        state_next = ghlsq_pkg::S_CL1;
      end
      ghlsq_pkg::S_CL1: begin
        if (it == '0) begin
          state_next = ghlsq_pkg::S_LO0;
        end else begin
          h_raddr    = ghlsq_pkg::haddr(ROW_W'(1), it);
          cs_raddr   = '0;
          state_next = ghlsq_pkg::S_RT0;
        end
      end
      ghlsq_pkg::S_RT0: state_next = ghlsq_pkg::S_RT1;
      ghlsq_pkg::S_RT1: begin
        mul_a      = c_reg;
        mul_b      = a_reg;
        state_next = ghlsq_pkg::S_RT2;
      end
      ghlsq_pkg::S_RT2: begin
        mul_a      = s_reg;
        mul_b      = b_reg;
        state_next = ghlsq_pkg::S_RT3;
      end
      ghlsq_pkg::S_RT3: begin
        mul_a      = s_reg;
        mul_b      = a_reg;
        state_next = ghlsq_pkg::S_RT4;
      end
      ghlsq_pkg::S_RT4: begin
        h_we       = 1'b1;
        h_waddr    = ghlsq_pkg::haddr(ROW_W'(j), it);
        h_wdata    = ghlsq_pkg::sat_acc(acc);
        mul_a      = c_reg;
        mul_b      = b_reg;
        state_next = ghlsq_pkg::S_RT5;
      end
      ghlsq_pkg::S_RT5: begin
        if (int'(j) + 1 == int'(it)) begin
          state_next = ghlsq_pkg::S_LO0;
        end else begin
          h_raddr    = ghlsq_pkg::haddr(ROW_W'(int'(j) + 2), it);
          cs_raddr   = COL_W'(int'(j) + 1);
          state_next = ghlsq_pkg::S_RT0;
        end
      end
      ghlsq_pkg::S_LO0: begin
        h_we       = 1'b1;
        h_waddr    = ghlsq_pkg::haddr(ROW_W'(it), it);
        h_wdata    = a_reg;
        h_raddr    = ghlsq_pkg::haddr(ROW_W'(int'(it) + 1), it);
        r_raddr    = CNT_W'(it);
        state_next = ghlsq_pkg::S_LO1;
      end
      ghlsq_pkg::S_LO1: state_next = ghlsq_pkg::S_SQ0;
      ghlsq_pkg::S_SQ0: begin
        mul_a         = a_reg;
        mul_b         = a_reg;
        div_req.start = 1'b1;
        div_req.num   = lo;
        div_req.den   = rv;
        state_next    = ghlsq_pkg::S_SQ1;
      end
      ghlsq_pkg::S_SQ1: begin
        mul_a      = lo;
        mul_b      = lo;
        state_next = ghlsq_pkg::S_SQ2;
      end
      ghlsq_pkg::S_SQ2: state_next = ghlsq_pkg::S_SQ3;
      ghlsq_pkg::S_SQ3: begin
        sqrt_req.start    = 1'b1;
        sqrt_req.radicand = sq;
        state_next        = ghlsq_pkg::S_WAIT;
      end
      ghlsq_pkg::S_WAIT: begin
        if (!div_rsp.busy && !sqrt_rsp.busy) begin
          state_next = ghlsq_pkg::S_DEC;
        end
      end
      ghlsq_pkg::S_DEC: begin
        if (brk) begin
          c_we       = 1'b1;
          c_wdata    = ghlsq_pkg::ONE_Q;
          s_we       = 1'b1;
          s_wdata    = '0;
          r_we       = 1'b1;
          r_waddr    = CNT_W'(int'(it) + 1);
          r_wdata    = '0;
          state_next = ghlsq_pkg::S_EMIT;
        end else begin
          state_next = ghlsq_pkg::S_DC;
        end
      end
      ghlsq_pkg::S_DC: begin
        div_req.start = 1'b1;
        div_req.num   = a_reg;
        div_req.den   = delta;
        state_next    = ghlsq_pkg::S_DCW;
      end
      ghlsq_pkg::S_DCW: begin
        if (!div_rsp.busy) begin
          state_next = ghlsq_pkg::S_DS;
        end
      end
      ghlsq_pkg::S_DS: begin
        div_req.start = 1'b1;
        div_req.num   = lo;
        div_req.den   = delta;
        state_next    = ghlsq_pkg::S_DSW;
      end
      ghlsq_pkg::S_DSW: begin
        if (!div_rsp.busy) begin
          state_next = ghlsq_pkg::S_N0;
        end
      end
      ghlsq_pkg::S_N0: begin
        c_we       = 1'b1;
        c_wdata    = c_reg;
        s_we       = 1'b1;
        s_wdata    = s_reg;
        mul_a      = c_reg;
        mul_b      = a_reg;
        state_next = ghlsq_pkg::S_N1;
      end
      ghlsq_pkg::S_N1: begin
        mul_a      = s_reg;
        mul_b      = lo;
        state_next = ghlsq_pkg::S_N2;
      end
      ghlsq_pkg::S_N2: begin
        h_we       = 1'b1;
        h_waddr    = ghlsq_pkg::haddr(ROW_W'(it), it);
        h_wdata    = ghlsq_pkg::sat_acc(acc + ACC_W'(rp));
        mul_a      = s_reg;
        mul_b      = rv;
        state_next = ghlsq_pkg::S_N3;
      end
      ghlsq_pkg::S_N3: begin
        r_we       = 1'b1;
        r_waddr    = CNT_W'(int'(it) + 1);
        r_wdata    = rneg;
        mul_a      = c_reg;
        mul_b      = rv;
        state_next = ghlsq_pkg::S_N4;
      end
      ghlsq_pkg::S_N4: begin
        r_we       = 1'b1;
        r_waddr    = CNT_W'(it);
        r_wdata    = ghlsq_pkg::sat_acc(ACC_W'(rp));
        state_next = ghlsq_pkg::S_EMIT;
      end
      ghlsq_pkg::S_SV1: state_next = ghlsq_pkg::S_SV2;
      ghlsq_pkg::S_SV2: begin
        if (hd != '0) begin
          div_req.start = 1'b1;
          div_req.num   = rv;
          div_req.den   = hd;
        end
        state_next = ghlsq_pkg::S_XW;
      end
      ghlsq_pkg::S_XW: begin
        if (!div_rsp.busy) begin
          x_we       = 1'b1;
          x_waddr    = k;
          x_wdata    = zflag ? '0 : div_rsp.quot;
          state_next = ghlsq_pkg::S_EMIT;
        end
      end
      ghlsq_pkg::S_K0: begin
        h_raddr    = ghlsq_pkg::haddr(ROW_W'(k), COL_W'(k));
        r_raddr    = k;
        state_next = ghlsq_pkg::S_K1;
      end
      ghlsq_pkg::S_K1: begin
        h_raddr    = ghlsq_pkg::haddr(ROW_W'(k), COL_W'(int'(k) + 1));
        x_raddr    = CNT_W'(int'(k) + 1);
        state_next = ghlsq_pkg::S_KJ0;
      end
      ghlsq_pkg::S_KJ0: begin
        mul_a      = h_q;
        mul_b      = x_q;
        state_next = ghlsq_pkg::S_KJ1;
      end
      ghlsq_pkg::S_KJ1: begin
        if (j == top) begin
          state_next = ghlsq_pkg::S_KD;
        end else begin
          h_raddr    = ghlsq_pkg::haddr(ROW_W'(k), COL_W'(int'(j) + 1));
          x_raddr    = CNT_W'(int'(j) + 1);
          state_next = ghlsq_pkg::S_KJ0;
        end
      end
      ghlsq_pkg::S_KD: begin
        div_req.start = 1'b1;
        div_req.num   = ghlsq_pkg::sat_acc(acc);
        div_req.den   = hd;
        state_next    = ghlsq_pkg::S_XW;
      end
      ghlsq_pkg::S_EMIT: begin
        if (emit_go) begin
          state_next = e_ret;
        end
      end
      default: state_next = ghlsq_pkg::S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cc <= '0;
    end else begin
      case (state)
        ghlsq_pkg::S_DISP: begin
          if (item.opcode == ghlsq_pkg::OP_START) begin
            cc <= '0;
          end
        end
        ghlsq_pkg::S_DEC: begin
          if (brk) begin
            cc <= CNT_W'(int'(it) + 1);
          end
        end
        ghlsq_pkg::S_N4: cc <= CNT_W'(int'(it) + 1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ghlsq_pkg::S_IDLE: begin
        if (cmd.valid) begin
          item <= cmd.payload;
        end
      end
      ghlsq_pkg::S_DISP: begin
        it    <= COL_W'(cc);
        j     <= '0;
        top   <= cc - CNT_W'(1);
        k     <= cc - CNT_W'(1);
        e_ret <= ghlsq_pkg::S_IDLE;
        if (item.opcode == ghlsq_pkg::OP_SOLVE) begin
          e_item <= '{ghlsq_pkg::KIND_COEF, '0, '0, ghlsq_pkg::ST_EMPTY, 1'b1};
        end else begin
          e_item <= '{ghlsq_pkg::KIND_RESID, '0, '0, ghlsq_pkg::ST_FULL, 1'b1};
        end
      end
      ghlsq_pkg::S_CL1: a_reg <= h_q;
      ghlsq_pkg::S_RT0: begin
        b_reg <= h_q;
        c_reg <= c_q;
        s_reg <= s_q;
      end
      ghlsq_pkg::S_RT2: acc <= ACC_W'(rp);
      ghlsq_pkg::S_RT4: acc <= -ACC_W'(rp);
      ghlsq_pkg::S_RT3: acc <= acc + ACC_W'(rp);
      ghlsq_pkg::S_RT5: begin
        a_reg <= ghlsq_pkg::sat_acc(acc + ACC_W'(rp));
        j     <= j + CNT_W'(1);
      end
      ghlsq_pkg::S_LO1: begin
        lo <= h_q;
        rv <= r_q;
      end
      ghlsq_pkg::S_SQ1: sq <= p;
      ghlsq_pkg::S_SQ2: sq <= sq + p;
      ghlsq_pkg::S_WAIT: begin
        delta <= sqrt_rsp.root[DW-1] ? ghlsq_pkg::VMAX : sqrt_rsp.root;
      end
      ghlsq_pkg::S_DEC: begin
        e_ret  <= ghlsq_pkg::S_IDLE;
        e_item <= '{ghlsq_pkg::KIND_RESID, '0, '0,
                    happy ? ghlsq_pkg::ST_HAPPY : ghlsq_pkg::ST_NULL, 1'b1};
      end
      ghlsq_pkg::S_DCW: c_reg <= div_rsp.quot;
      ghlsq_pkg::S_DSW: s_reg <= div_rsp.quot;
      ghlsq_pkg::S_N1: acc <= ACC_W'(rp);
      ghlsq_pkg::S_N3: begin
        e_item <= '{ghlsq_pkg::KIND_RESID, ghlsq_pkg::abs_q(rneg), '0,
                    ghlsq_pkg::ST_OK, 1'b1};
      end
      ghlsq_pkg::S_SV1: begin
        hd <= h_q;
        rv <= r_q;
      end
      ghlsq_pkg::S_SV2: zflag <= (hd == '0);
      ghlsq_pkg::S_XW: begin
        if (!div_rsp.busy) begin
          e_item <= '{ghlsq_pkg::KIND_COEF, zflag ? '0 : div_rsp.quot,
                      ghlsq_pkg::IDX_W'(k), ghlsq_pkg::ST_OK, k == '0};
          e_ret  <= (k == '0) ? ghlsq_pkg::S_IDLE : ghlsq_pkg::S_K0;
          if (k != '0) begin
            k <= k - CNT_W'(1);
          end
        end
      end
      ghlsq_pkg::S_K1: begin
        acc <= ACC_W'(r_q);
        hd  <= h_q;
        j   <= k + CNT_W'(1);
      end
      ghlsq_pkg::S_KJ1: begin
        acc <= acc - ACC_W'(rp);
        if (j != top) begin
          j <= j + CNT_W'(1);
        end
      end
      ghlsq_pkg::S_KD: zflag <= 1'b0;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (state == ghlsq_pkg::S_EMIT && emit_go) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ghlsq_pkg::S_EMIT && emit_go) begin
      o_item <= e_item;
    end
  end

  assign rsp.valid   = o_valid;
  assign rsp.payload = o_item;

  assign start_acc = cmd.valid && cmd.ready && (cmd.payload.opcode == ghlsq_pkg::OP_START);
  assign seq_idle  = (state == ghlsq_pkg::S_IDLE) && !o_valid;

  `GH_ASSERT(a_cnt_bound, clk, rst, cc <= CNT_W'(MAXC), "column count above capacity")
  `GH_ASSERT(a_start_clear, clk, rst, start_acc |=> ##1 (cc == '0), "start kept column count")
  `GH_ASSERT(a_div_idle, clk, rst, div_req.start |-> !div_rsp.busy, "divider restarted")
  `GH_ASSERT_ALWAYS(a_rst_state, clk, rst |=> seq_idle, "reset left sequencer active")

endmodule

// ===== test/tb_givens_hessenberg_lsq_update.sv =====
`timescale 1ns / 100ps

module tb_givens_hessenberg_lsq_update;
  import ghlsq_pkg::*;

  localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE = 600;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  ghlsq_in_if cmd_if();
  ghlsq_out_if rsp_if();

  givens_hessenberg_lsq_update i_dut (
    .clk(clk), .rst(rst), .cmd(cmd_if), .rsp(rsp_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // model state
  data_t hstore [0:MAX_COLUMNS+1][0:MAX_COLUMNS-1];
  data_t cos_tab [0:MAX_COLUMNS-1];
  data_t sin_tab [0:MAX_COLUMNS-1];
  data_t rhs_vec [0:MAX_COLUMNS];
  data_t coef_vec [0:MAX_COLUMNS];
  int ncols;
  longint tol_q;
  int act_cols;

  in_item_t pending_req [$];
  out_item_t expected_res [$];

  int errors, n_req, n_close, n_happy, n_null, n_full, n_solve, cycles;
  int send_gap, recv_gap, gen_cnt, gen_lim;
  bit calm;

  initial begin
    clk = 0;
    rst = 1;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    cmd_if.valid = 0;
    cmd_if.payload = '0;
    rsp_if.ready = 0;
    forever #5 clk = ~clk;
  end

  function automatic data_t sat(longint x);
    if (x > longint'(VMAX)) return VMAX;
    if (x < longint'(VMIN)) return VMIN;
    return data_t'(x);
  endfunction

  function automatic longint mulq(longint a, longint b);
    longint p;
    p = a * b + 64'sd32768;
    return p >>> 16;
  endfunction

  function automatic longint divq(longint a, longint b);
    if (b == 0) return a > 0 ? longint'(VMAX) : (a < 0 ? longint'(VMIN) : 0);
    return longint'(sat((a * 65536) / b));
  endfunction

  function automatic longint absq(longint x);
    return longint'(sat(x < 0 ? -x : x));
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void push_result(logic kind, data_t val, int idx, logic [STAT_W-1:0] st,
                                      logic last);
    out_item_t o;
    o.result_kind = kind;
    o.result_value = val;
    o.coefficient_index = IDX_W'(idx);
    o.status = st;
    o.last_result = last;
    expected_res.push_back(o);
  endfunction

  task automatic close_column();
    int it;
    longint a, b, hi, lo, bnd, delta, c, s, r;
    longint unsigned sq;
    bit happy;
    it = ncols;
    for (int j = 0; j < it; j++) begin
      a = hstore[j][it];
      b = hstore[j+1][it];
      hstore[j][it] = sat(mulq(cos_tab[j], a) + mulq(sin_tab[j], b));
      hstore[j+1][it] = sat(-mulq(sin_tab[j], a) + mulq(cos_tab[j], b));
    end
    hi = hstore[it][it];
    lo = hstore[it+1][it];
    bnd = absq(divq(lo, rhs_vec[it]));
    if (tol_q < bnd) bnd = tol_q;
    sq = longint'(hi * hi) + longint'(lo * lo);
    delta = longint'(sat(longint'(isqrt(sq))));
    happy = absq(lo) < bnd;
    n_close++;
    ncols = it + 1;
    if (happy || delta == 0) begin
      cos_tab[it] = ONE_Q;
      sin_tab[it] = 0;
      rhs_vec[it+1] = 0;
      if (happy) n_happy++;
      else n_null++;
      push_result(KIND_RESID, 0, 0, happy ? ST_HAPPY : ST_NULL, 1'b1);
    end else begin
      c = divq(hi, delta);
      s = divq(lo, delta);
      cos_tab[it] = data_t'(c);
      sin_tab[it] = data_t'(s);
      hstore[it][it] = sat(mulq(c, hi) + mulq(s, lo));
      r = rhs_vec[it];
      rhs_vec[it+1] = sat(-mulq(s, r));
      rhs_vec[it] = sat(mulq(c, r));
      push_result(KIND_RESID, data_t'(absq(rhs_vec[it+1])), 0, ST_OK, 1'b1);
    end
  endtask

  task automatic back_substitute();
    int top;
    longint acc;
    n_solve++;
    if (ncols == 0) begin
      push_result(KIND_COEF, 0, 0, ST_EMPTY, 1'b1);
    end else begin
      top = ncols - 1;
      coef_vec[top] = hstore[top][top] != 0 ? data_t'(divq(rhs_vec[top], hstore[top][top])) : 0;
      push_result(KIND_COEF, coef_vec[top], top, ST_OK, top == 0);
      for (int k = top - 1; k >= 0; k--) begin
        acc = rhs_vec[k];
        for (int j = k + 1; j <= top; j++) acc -= mulq(hstore[k][j], coef_vec[j]);
        coef_vec[k] = data_t'(divq(sat(acc), hstore[k][k]));
        push_result(KIND_COEF, coef_vec[k], k, ST_OK, k == 0);
      end
    end
  endtask

  task automatic predict(in_item_t req);
    int lim;
    lim = act_cols < 1 ? 1 : (act_cols > MAX_COLUMNS ? MAX_COLUMNS : act_cols);
    case (req.opcode)
      OP_START: begin
        rhs_vec[0] = req.data_value;
        ncols = 0;
      end
      OP_ENTRY: begin
        if (ncols >= lim) begin
          if (req.column_end) begin
            n_full++;
            push_result(KIND_RESID, 0, 0, ST_FULL, 1'b1);
          end
        end else begin
          if (req.row_index <= ncols + 1) hstore[req.row_index][ncols] = req.data_value;
          if (req.column_end) close_column();
        end
      end
      OP_SOLVE: back_substitute();
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 63) == 0) calm = !calm;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // send side
  always @(posedge clk) begin
    if (rst) begin
      cmd_if.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) predict(cmd_if.payload);
      if (!cmd_if.valid || cmd_if.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          cmd_if.valid <= 1'b0;
        end else if (pending_req.size() > 0) begin
          cmd_if.payload <= pending_req.pop_front();
          cmd_if.valid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // receive side
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_res.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: kind %0d value %0d index %0d status %0d last %0d",
                     rsp_if.payload.result_kind, rsp_if.payload.result_value,
                     rsp_if.payload.coefficient_index, rsp_if.payload.status,
                     rsp_if.payload.last_result);
        end else begin
          out_item_t e;
          out_item_t g;
          e = expected_res.pop_front();
          g = rsp_if.payload;
          if (g.result_kind !== e.result_kind || g.result_value !== e.result_value ||
              g.coefficient_index !== e.coefficient_index || g.status !== e.status ||
              g.last_result !== e.last_result) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected kind %0d value %0d index %0d status %0d last %0d, got kind %0d value %0d index %0d status %0d last %0d",
                       e.result_kind, e.result_value, e.coefficient_index, e.status,
                       e.last_result, g.result_kind, g.result_value, g.coefficient_index,
                       g.status, g.last_result);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [APB_DW-1:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_TOL) tol_q = v & 32'h7FFF_FFFF;
    else act_cols = v & 32'h3F;
  endtask

  task automatic push_req(logic [OPC_W-1:0] op, int row, data_t val, logic fin);
    in_item_t q;
    q.opcode = op;
    q.row_index = ROWIN_W'(row);
    q.data_value = val;
    q.column_end = fin;
    pending_req.push_back(q);
    n_req++;
  endtask

  function automatic data_t rand_q();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return VMIN;
    if (r == 1) return VMAX;
    if (r == 2) return 0;
    if (r < 6) return data_t'($urandom);
    if (r < 8) return data_t'($urandom_range(0, 255)) - 128;
    return data_t'($urandom_range(0, 1 << 19)) - (1 << 18);
  endfunction

  task automatic drain();
    while (pending_req.size() > 0 || cmd_if.valid || expected_res.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic add_session(int cols);
    int lim;
    lim = gen_lim < 1 ? 1 : (gen_lim > MAX_COLUMNS ? MAX_COLUMNS : gen_lim);
    push_req(OP_START, $urandom_range(0, 63), rand_q(), $urandom_range(0, 1));
    gen_cnt = 0;
    for (int c = 0; c < cols; c++) begin
      if ($urandom_range(0, 24) == 0) begin
        // abandon a column halfway
        push_req(OP_ENTRY, 0, rand_q(), 1'b0);
        return;
      end
      if (gen_cnt < lim) begin
        for (int r = 0; r <= gen_cnt + 1; r++) begin
          if ($urandom_range(0, 15) == 0)
            push_req(OP_ENTRY, $urandom_range(gen_cnt + 2, 63), rand_q(), 1'b0);
          if ($urandom_range(0, 31) == 0)
            push_req(OP_UNUSED, $urandom_range(0, 63), rand_q(), $urandom_range(0, 1));
          push_req(OP_ENTRY, r, rand_q(), r == gen_cnt + 1);
        end
        gen_cnt++;
      end else begin
        push_req(OP_ENTRY, $urandom_range(0, 63), rand_q(), 1'b0);
        push_req(OP_ENTRY, $urandom_range(0, 63), rand_q(), 1'b1);
      end
    end
    if ($urandom_range(0, 3) != 0) push_req(OP_SOLVE, $urandom_range(0, 63), rand_q(), 1'b0);
  endtask

  initial begin
    int target;
    int tol_set [4];
    int act_set [4];
    errors = 0;
    cycles = 0;
    calm = 0;
    ncols = 0;
    tol_q = 0;
    act_cols = 30;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    push_req(OP_SOLVE, 0, 0, 1'b0);
    push_req(OP_UNUSED, 63, VMAX, 1'b1);
    push_req(OP_START, 0, VMIN, 1'b0);
    push_req(OP_ENTRY, 0, VMAX, 1'b0);
    push_req(OP_ENTRY, 1, VMIN, 1'b1);
    push_req(OP_ENTRY, 0, 0, 1'b0);
    push_req(OP_ENTRY, 1, 0, 1'b0);
    push_req(OP_ENTRY, 2, 0, 1'b1);
    push_req(OP_ENTRY, 63, VMAX, 1'b0);
    push_req(OP_ENTRY, 0, 32'sh0001_8000, 1'b0);
    push_req(OP_ENTRY, 1, -32'sh0002_0000, 1'b0);
    push_req(OP_ENTRY, 2, 32'sh0000_4000, 1'b0);
    push_req(OP_ENTRY, 3, 32'sh0001_0000, 1'b1);
    push_req(OP_SOLVE, 0, 0, 1'b0);
    push_req(OP_START, 0, 32'sh0001_0000, 1'b0);
    push_req(OP_SOLVE, 0, 0, 1'b0);
    drain();

    write_reg(REG_TOL, 32'h7FFF_FFFF);
    write_reg(REG_ACT, 32'd1);
    push_req(OP_START, 0, 32'sh0000_4000, 1'b0);
    push_req(OP_ENTRY, 0, 32'sh0001_0000, 1'b0);
    push_req(OP_ENTRY, 1, 32'sh0000_8000, 1'b1);
    push_req(OP_ENTRY, 0, VMAX, 1'b0);
    push_req(OP_ENTRY, 1, VMIN, 1'b1);
    push_req(OP_SOLVE, 0, 0, 1'b0);
    drain();

    tol_set = '{32'h0000_0800, 0, 32'h7FFF_FFFF, 32'h0001_0000};
    act_set = '{4, 32, 1, 30};
    target = n_req;
    for (int p = 0; p < 4; p++) begin
      if (p == 3) begin
        tol_set[p] = $urandom_range(0, 32'h0004_0000);
        act_set[p] = $urandom_range(2, 8);
      end
      write_reg(REG_TOL, tol_set[p]);
      write_reg(REG_ACT, act_set[p]);
      gen_lim = act_set[p];
      target += 115;
      while (n_req < target) begin
        if ($urandom_range(0, 7) == 0) add_session(gen_lim < 9 ? gen_lim + 2 : 10);
        else add_session($urandom_range(1, 6));
      end
      drain();
    end

    if (expected_res.size() != 0) errors++;
    $display("%0d requests sent; %0d columns closed (%0d happy, %0d null), %0d full, %0d solves",
             n_req, n_close, n_happy, n_null, n_full, n_solve);
    $display("%0d mismatches", errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
